>>> sv/rtp_pkg.sv
// ----------------------------------------------------------------------------
// Round-trip timer package
// Shared widths, slot marks, status codes and the queue entry type.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int KeyWidth   = 31;
  localparam int StampWidth = 20;
  localparam int MsWidth    = 10;
  localparam int DefaultDepth = 128;
  localparam int WrapUs  = 1000000;
  localparam int UsPerMs = 1000;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2,
    MARK_SPARE = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_FULL     = 2'd1,
    ST_MATCHED  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic                  mode;
    logic [KeyWidth-1:0]   key;
    logic [StampWidth-1:0] stamp;
  } cmd_t;

endpackage

>>> sv/rtp_front.sv
// ----------------------------------------------------------------------------
// Round-trip timer front queue
// Accepts transactions into a two-entry queue for the probe engine.
// ----------------------------------------------------------------------------
module rtp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rtp_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output rtp_pkg::cmd_t cmd
);
  import rtp_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("front queue count out of range");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !do_pop) else $error("front queue popped empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 2'd1)
    else $error("front queue count did not rise");

endmodule

>>> sv/rtp_engine.sv
// ----------------------------------------------------------------------------
// Round-trip timer probe engine
// Walks the probe chain one slot at a time, reading each slot and then probing
// it, updates marks and forms the result.
// ----------------------------------------------------------------------------
module rtp_engine #(
  parameter int TABLE_DEPTH = rtp_pkg::DefaultDepth
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_take,
  input  rtp_pkg::cmd_t                    cmd,
  output logic                             res_valid,
  input  logic                             res_take,
  output logic [1:0]                       status,
  output logic [rtp_pkg::StampWidth-1:0]   sent_time_us,
  output logic [rtp_pkg::MsWidth-1:0]      rtt_ms
);
  import rtp_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int DiffW = 22;
  localparam int HomeShift = KeyWidth + IdxW;
  localparam logic [31:0] HomeMul = 32'((64'd1 << HomeShift) / 64'(TABLE_DEPTH));
  localparam logic [IdxW:0] DepthW = (IdxW+1)'(TABLE_DEPTH);
  localparam int MsShift = 29;
  localparam int ProdW = 2 * StampWidth;
  localparam int MsMul = (2 ** MsShift + UsPerMs - 1) / UsPerMs;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HASH, S_HOME, S_READ, S_PROBE, S_WRAP, S_RTT, S_MS, S_DONE
  } state_t;

  state_t state;
  logic [KeyWidth-1:0]   key_mem   [TABLE_DEPTH];
  logic [StampWidth-1:0] stamp_mem [TABLE_DEPTH];
  logic [1:0]            mark_mem  [TABLE_DEPTH];

  logic [IdxW-1:0]       idx;
  logic [CntW-1:0]       probes;
  cmd_t                  cur;
  logic [KeyWidth-1:0]   rd_key;
  logic [StampWidth-1:0] rd_stamp;
  logic [1:0]            rd_mark;
  logic                  found;
  logic [StampWidth-1:0] sent;
  logic [DiffW-1:0]      diff;
  logic [IdxW-1:0]       idx_next;
  logic                  mem_we;
  logic [1:0]            mem_mark;
  logic                  kv_we;
  logic [63:0]           home_prod;
  logic [IdxW:0]         quot_low;
  logic [IdxW:0]         rem_est;
  logic [IdxW-1:0]       home;

  assign idx_next = (idx == IdxW'(TABLE_DEPTH - 1)) ? '0 : idx + 1'b1;
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign res_valid = (state == S_DONE);

  // The home slot is the key modulo the depth, by a reciprocal multiply whose
  // quotient is at most one short, then a single corrective subtraction.
  assign home_prod = 64'(cur.key) * 64'(HomeMul);
  assign rem_est   = cur.key[IdxW:0] - (IdxW+1)'(quot_low * DepthW);
  assign home      = (rem_est >= DepthW) ? IdxW'(rem_est - DepthW) : IdxW'(rem_est);

  always_ff @(posedge clk) begin
    if (state == S_HASH) quot_low <= home_prod[HomeShift +: IdxW+1];
  end

  always_comb begin
    mem_we   = 1'b0;
    kv_we    = 1'b0;
    mem_mark = MARK_EMPTY;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_PROBE) begin
      if (!cur.mode && rd_mark != MARK_USED) begin
        mem_we = 1'b1;
        kv_we = 1'b1;
        mem_mark = MARK_USED;
      end else if (cur.mode && rd_mark == MARK_USED && rd_key == cur.key) begin
        mem_we = 1'b1;
        mem_mark = MARK_GONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mark_mem[idx] <= mem_mark;
    if (kv_we) begin
      key_mem[idx]   <= cur.key;
      stamp_mem[idx] <= cur.stamp;
    end
    rd_key   <= key_mem[idx];
    rd_stamp <= stamp_mem[idx];
    rd_mark  <= mark_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      probes <= '0;
      found  <= 1'b0;
      status <= ST_STORED;
    end else begin
      unique case (state)
        S_CLEAR: begin
          idx <= idx_next;
          if (idx == IdxW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            probes <= '0;
            found  <= 1'b0;
            sent   <= '0;
            state  <= S_HASH;
          end
        end
        S_HASH: state <= S_HOME;
        S_HOME: begin
          idx   <= home;
          state <= S_READ;
        end
        S_READ: state <= S_PROBE;
        S_PROBE: begin
          idx    <= idx_next;
          probes <= probes + 1'b1;
          state  <= S_READ;
          if (!cur.mode) begin
            if (rd_mark != MARK_USED) begin
              status <= ST_STORED;
              state  <= S_DONE;
            end else if (probes == CntW'(TABLE_DEPTH - 1)) begin
              status <= ST_FULL;
              state  <= S_DONE;
            end
          end else begin
            if (rd_mark == MARK_USED && rd_key == cur.key && !found) begin
              found <= 1'b1;
              sent  <= rd_stamp;
            end
            if (rd_mark == MARK_EMPTY || probes == CntW'(TABLE_DEPTH - 1)) begin
              state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          diff  <= {2'b00, cur.stamp} + DiffW'(2 * WrapUs) - {2'b00, sent};
          state <= S_RTT;
        end
        S_RTT: begin
          state <= S_MS;
          status <= found ? ST_MATCHED : ST_NOTFOUND;
        end
        S_MS: state <= S_DONE;
        S_DONE: if (res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [DiffW-1:0]      red;
  logic [StampWidth-1:0] mod_us;
  logic [StampWidth-1:0] mod_q;
  logic [ProdW-1:0]      ms_prod;
  logic [MsWidth-1:0]    ms_q;

  always_comb begin
    priority if (diff >= DiffW'(3 * WrapUs)) begin
      red = diff - DiffW'(3 * WrapUs);
    end else if (diff >= DiffW'(2 * WrapUs)) begin
      red = diff - DiffW'(2 * WrapUs);
    end else if (diff >= DiffW'(WrapUs)) begin
      red = diff - DiffW'(WrapUs);
    end else begin
      red = diff;
    end
  end

  assign mod_us  = red[StampWidth-1:0];
  assign ms_prod = ProdW'(mod_q) * ProdW'(MsMul);

  always_ff @(posedge clk) begin
    if (state == S_RTT) mod_q <= mod_us;
    if (state == S_MS) ms_q <= MsWidth'(ms_prod >> MsShift);
  end

  assign sent_time_us = (status == ST_MATCHED) ? sent : '0;
  assign rtt_ms       = (status == ST_MATCHED) ? ms_q : '0;

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state == S_HASH) else $error("take did not start a probe");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> probes < CntW'(TABLE_DEPTH))
    else $error("probe count exceeded depth");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid && $stable(status))
    else $error("result changed before it was taken");

endmodule

>>> sv/rtt_timestamp_probe_table.sv
// ----------------------------------------------------------------------------
// Round-trip timestamp probe table
// Linear-probing table of send times, matched against responses.
// ----------------------------------------------------------------------------
// channel  handshake    fields
// input    push / full  mode, pkt_seq, time_us
// result   empty / pop  status, sent_time_us, rtt_ms
//
// A send or a response probes at most TABLE_DEPTH slots, and the engine takes the
// next transaction only once the result of the last one has been popped.
// After reset a clearing pass over all TABLE_DEPTH slots empties the slot marks,
// while full stays high once the two-entry input queue is filled.
// The input queue keeps taking transactions while a result waits for pop.
// ----------------------------------------------------------------------------
module rtt_timestamp_probe_table #(
  parameter int TABLE_DEPTH = rtp_pkg::DefaultDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode,
  input  logic [rtp_pkg::KeyWidth-1:0]   pkt_seq,
  input  logic [rtp_pkg::StampWidth-1:0] time_us,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     status,
  output logic [rtp_pkg::StampWidth-1:0] sent_time_us,
  output logic [rtp_pkg::MsWidth-1:0]    rtt_ms
);
  import rtp_pkg::*;

  cmd_t in_cmd;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic res_valid;

  assign in_cmd = '{mode: mode, key: pkt_seq, stamp: time_us};
  assign empty  = !res_valid;

  rtp_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_cmd(in_cmd),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  rtp_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .res_valid(res_valid), .res_take(pop), .status(status),
    .sent_time_us(sent_time_us), .rtt_ms(rtt_ms)
  );

endmodule

>>> tb/rtt_timestamp_probe_table_test.sv
// ----------------------------------------------------------------------------
// Round-trip timestamp probe table testbench
// Drives send and response transactions through the input queue, predicts
// each result with a local linear-probing table, and compares every popped
// result field by field, under several idling phases on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtt_timestamp_probe_table_test;
  import rtp_pkg::*;

  localparam int Depth = DefaultDepth;

  typedef struct packed {
    logic [1:0]            status;
    logic [StampWidth-1:0] sent;
    logic [MsWidth-1:0]    ms;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic mode = 1'b0;
  logic [KeyWidth-1:0] pkt_seq = '0;
  logic [StampWidth-1:0] time_us = '0;
  logic full, empty;
  logic [1:0] status;
  logic [StampWidth-1:0] sent_time_us;
  logic [MsWidth-1:0] rtt_ms;

  cmd_t    pending_cmds[$];
  result_t expected_results[$];
  logic [KeyWidth-1:0]   tbl_key[Depth];
  logic [StampWidth-1:0] tbl_stamp[Depth];
  mark_t                 tbl_mark[Depth];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic started = 1'b0;
  logic in_taken = 1'b0;
  logic [KeyWidth-1:0] recent_keys[$];

  rtt_timestamp_probe_table u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .pkt_seq(pkt_seq), .time_us(time_us), .empty(empty), .pop(pop),
    .status(status), .sent_time_us(sent_time_us), .rtt_ms(rtt_ms)
  );

  always #4 clk = ~clk;

  function automatic result_t probe_table(cmd_t c);
    result_t r;
    int idx;
    logic found;
    logic [StampWidth-1:0] sent;
    int d;
    r = '0;
    idx = c.key % Depth;
    found = 1'b0;
    sent = '0;
    if (c.mode == 1'b0) begin
      r.status = ST_FULL;
      for (int n = 0; n < Depth; n++) begin
        if (tbl_mark[idx] != MARK_USED) begin
          tbl_key[idx] = c.key;
          tbl_stamp[idx] = c.stamp;
          tbl_mark[idx] = MARK_USED;
          r.status = ST_STORED;
          break;
        end
        idx = (idx + 1) % Depth;
      end
    end else begin
      for (int n = 0; n < Depth; n++) begin
        if (tbl_mark[idx] == MARK_EMPTY) break;
        if (tbl_mark[idx] == MARK_USED && tbl_key[idx] == c.key) begin
          if (!found) sent = tbl_stamp[idx];
          found = 1'b1;
          tbl_mark[idx] = MARK_GONE;
        end
        idx = (idx + 1) % Depth;
      end
      if (found) begin
        d = (int'(c.stamp) - int'(sent) + 2 * WrapUs) % WrapUs;
        r.status = ST_MATCHED;
        r.sent = sent;
        r.ms = MsWidth'(d / UsPerMs);
      end else begin
        r.status = ST_NOTFOUND;
      end
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void add_cmd(logic m, logic [KeyWidth-1:0] k, logic [StampWidth-1:0] t);
    cmd_t c;
    c.mode = m;
    c.key = k;
    c.stamp = t;
    pending_cmds.push_back(c);
  endfunction

  always @(negedge clk) begin
    cmd_t c;
    if (started && pending_cmds.size() > 0 && (!push || in_taken)
        && $urandom_range(99) >= send_idle) begin
      c = pending_cmds.pop_front();
      push <= 1'b1;
      mode <= c.mode;
      pkt_seq <= c.key;
      time_us <= c.stamp;
    end else if (in_taken) begin
      push <= 1'b0;
    end
    pop <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    in_taken <= push && !full;
    if (!rst && push && !full) begin
      expected_results.push_back(probe_table({mode, pkt_seq, time_us}));
    end
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report("unexpected result, status", status, 0);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (status !== e.status) report("status", status, e.status);
        if (sent_time_us !== e.sent) report("sent_time_us", sent_time_us, e.sent);
        if (rtt_ms !== e.ms) report("rtt_ms", rtt_ms, e.ms);
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int count, int idle, int stall);
    logic [KeyWidth-1:0] k;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 6 || recent_keys.size() == 0) begin
        case ($urandom_range(3))
          0: k = {24'($urandom_range(255)), 7'($urandom_range(3))};
          1: k = KeyWidth'($urandom);
          2: k = {24'($urandom), 7'($urandom_range(Depth - 1))};
          default: k = KeyWidth'($urandom_range(40));
        endcase
        add_cmd(1'b0, k, StampWidth'($urandom));
        if (recent_keys.size() > 30) void'(recent_keys.pop_front());
        recent_keys.push_back(k);
      end else if ($urandom_range(4) != 0) begin
        k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        add_cmd(1'b1, k, StampWidth'($urandom));
      end else begin
        add_cmd(1'b1, KeyWidth'($urandom), StampWidth'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      tbl_key[i] = '0;
      tbl_stamp[i] = '0;
      tbl_mark[i] = MARK_EMPTY;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    started = 1'b1;
    add_cmd(1'b1, 31'd5, 20'd0);
    add_cmd(1'b0, 31'h7FFFFFFF, 20'd999999);
    add_cmd(1'b1, 31'h7FFFFFFF, 20'd0);
    add_cmd(1'b0, 31'd0, 20'd0);
    add_cmd(1'b0, 31'd128, 20'd500000);
    add_cmd(1'b0, 31'd0, 20'd1000);
    add_cmd(1'b1, 31'd0, 20'd999999);
    add_cmd(1'b1, 31'd128, 20'hFFFFF);
    add_cmd(1'b1, 31'd0, 20'd5);
    add_cmd(1'b0, 31'd1, 20'hFFFFF);
    add_cmd(1'b1, 31'd1, 20'd0);
    add_cmd(1'b0, 31'd256, 20'd7);
    add_cmd(1'b1, 31'd256, 20'd7);
    drain();
    // Fill every slot so that further sends are dropped.
    for (int i = 0; i < Depth; i++) add_cmd(1'b0, KeyWidth'(i * 3), 20'(i));
    add_cmd(1'b0, 31'd9, 20'd1);
    add_cmd(1'b1, 31'd1000, 20'd1);
    drain();
    for (int i = 0; i < Depth; i++) add_cmd(1'b1, KeyWidth'(i * 3), 20'(i + 2000));
    drain();
    random_phase(200, 0, 0);
    random_phase(200, 50, 0);
    random_phase(200, 0, 50);
    random_phase(200, 22, 22);
    repeat (600) @(posedge clk);
    if (errors == 0)
      $display("rtt_timestamp_probe_table_test OK");
    else
      $display("rtt_timestamp_probe_table_test NOT OK");
    $finish;
  end

  initial begin
    #20000000;
    $display("rtt_timestamp_probe_table_test NOT OK");
    $finish;
  end

endmodule

>>> sim.f
sv/rtp_pkg.sv
sv/rtp_front.sv
sv/rtp_engine.sv
sv/rtt_timestamp_probe_table.sv
tb/rtt_timestamp_probe_table_test.sv
